// File: rtl/kmeans_pkg.sv
`default_nettype none
package kmeans_pkg;

   localparam int MaxClusters = 8;
   localparam int MaxDims     = 4;
   localparam int MaxPoints   = 1048576;

   localparam int ClW    = $clog2(MaxClusters);
   localparam int CoordW = 16;
   localparam int SumW   = 37;
   localparam int CntW   = 21;
   localparam int DistW  = 34;
   localparam int ErrW   = 54;
   localparam int DivCycW = 6;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ASSIGN = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [0:0] REG_CLUSTERS = 1'b0;
   localparam logic [0:0] REG_DIMS     = 1'b1;

   typedef struct packed {
      logic [1:0]               operation;
      logic [2:0]               cluster_select;
      logic signed [CoordW-1:0] coord0;
      logic signed [CoordW-1:0] coord1;
      logic signed [CoordW-1:0] coord2;
      logic signed [CoordW-1:0] coord3;
   } req_type;

   typedef struct packed {
      logic [2:0]               cluster;
      logic [DistW-1:0]         sq_distance;
      logic signed [CoordW-1:0] cent0;
      logic signed [CoordW-1:0] cent1;
      logic signed [CoordW-1:0] cent2;
      logic signed [CoordW-1:0] cent3;
      logic [CntW-1:0]          point_count;
      logic                     empty_cluster;
      logic [ErrW-1:0]          total_error;
      logic                     last;
   } rsp_type;

   // Lane divider handshake between the sequencer and the lanes.
   typedef struct packed {
      logic            start;
      logic [CntW-1:0] divisor;
   } div_ctl_type;

endpackage
`default_nettype wire

// File: rtl/kmeans_lane.sv
`default_nettype none
// One coordinate lane: squared difference and a restoring divider for the mean.
module kmeans_lane (
   input  wire logic                              clock,
   input  wire logic signed [kmeans_pkg::CoordW-1:0] point,
   input  wire logic signed [kmeans_pkg::CoordW-1:0] centroid,
   input  wire logic                              enable,
   output logic [kmeans_pkg::DistW-2:0]           sq_ff,
   input  wire kmeans_pkg::div_ctl_type           div_ctl,
   input  wire logic signed [kmeans_pkg::SumW-1:0] dividend,
   output logic signed [kmeans_pkg::CoordW-1:0]   quotient
);
   import kmeans_pkg::*;

   logic signed [CoordW:0] diff;
   logic [CoordW:0]        mag;
   logic [DistW-2:0]       sq_in;
   logic [SumW-1:0]        rem_ff, rem_in, quo_ff, quo_in;
   logic                   neg_ff, neg_in;
   logic [SumW:0]          trial;
   logic [SumW-1:0]        abs_div, q_signed;

   assign diff  = {point[CoordW-1], point} - {centroid[CoordW-1], centroid};
   assign mag   = diff[CoordW] ? -diff : diff;
   assign sq_in = enable ? (DistW-1)'(mag * mag) : '0;

   // Dividend bits shift in MSB first; remainder grows one bit per cycle.
   assign abs_div = dividend[SumW-1] ? -dividend : dividend;
   assign trial = {rem_ff, quo_ff[SumW-1]} - {(SumW+1-CntW)'(0), div_ctl.divisor};

   always_comb begin
      if (div_ctl.start) begin
         rem_in = '0;
         quo_in = abs_div;
         neg_in = dividend[SumW-1];
      end else begin
         neg_in = neg_ff;
         if (!trial[SumW]) begin
            rem_in = trial[SumW-1:0];
            quo_in = {quo_ff[SumW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[SumW-2:0], quo_ff[SumW-1]};
            quo_in = {quo_ff[SumW-2:0], 1'b0};
         end
      end
   end

   assign q_signed = neg_ff ? -quo_ff : quo_ff;
   assign quotient = q_signed[CoordW-1:0];

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

// File: rtl/kmeans_assign_and_update.sv
// Lloyd k-means engine. Four coordinate lanes work in parallel; a sequencer
// walks the active centroids one per cycle. A load writes the centroid when it
// is accepted. An assign steps through the accepting cycle, one distance
// pipeline pass per centroid, a drain of the compare, an accumulate step and a
// step that loads the result. An update steps, per active cluster, through the
// lanes' bit-serial mean divider, the write-back and a result step. A stalled
// result beat holds the sequencer until it is taken. A new item is taken once
// the previous result is in the output register.
`default_nettype none
module kmeans_assign_and_update (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire kmeans_pkg::req_type   req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output kmeans_pkg::rsp_type        rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [2:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import kmeans_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIST, S_MERGE, S_ADD, S_DIV, S_EMIT, S_OUT
   } state_type;

   state_type state_ff;
   logic [3:0] ncl_ff;
   logic [2:0] ndim_ff;
   logic [3:0] nk;
   logic [2:0] nd;

   logic signed [CoordW-1:0] cent_ff  [MaxClusters][MaxDims];
   logic signed [SumW-1:0]   sum_ff   [MaxClusters][MaxDims];
   logic [CntW-1:0]          cnt_ff   [MaxClusters];
   logic [ErrW-1:0]          err_ff;

   logic signed [CoordW-1:0] pt_ff [MaxDims];
   logic [ClW:0]    k_ff;        // cluster being issued
   logic [ClW:0]    kd_ff;       // cluster whose distance is in the lanes
   logic            dv_ff;
   logic [ClW-1:0]  best_ff;
   logic [DistW-1:0] bestd_ff;
   logic [DivCycW-1:0] dc_ff;
   logic            rv_ff, rv_in;
   rsp_type         rsp_ff;

   logic [DistW-2:0]        sq [MaxDims];
   logic signed [CoordW-1:0] quo [MaxDims];
   logic [DistW-1:0]        dsum;
   div_ctl_type             dctl;
   logic                    accept, out_free;

   assign nk = (ncl_ff == 0) ? 4'd1 : (ncl_ff > MaxClusters ? 4'(MaxClusters) : ncl_ff);
   assign nd = (ndim_ff == 0) ? 3'd1 : (ndim_ff > MaxDims ? 3'(MaxDims) : ndim_ff);

   assign out_free  = !rv_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {29'd0, ndim_ff} : {28'd0, ncl_ff};

   assign dctl.start   = (state_ff == S_DIV) && (dc_ff == 0);
   assign dctl.divisor = cnt_ff[k_ff[ClW-1:0]];

   for (genvar j = 0; j < MaxDims; j++) begin : g_lane
      kmeans_lane u_lane (
         .clock   (clock),
         .point   (pt_ff[j]),
         .centroid(cent_ff[k_ff[ClW-1:0]][j]),
         .enable  (3'(j) < nd),
         .sq_ff   (sq[j]),
         .div_ctl (dctl),
         .dividend(sum_ff[k_ff[ClW-1:0]][j]),
         .quotient(quo[j])
      );
   end

   // Merge of the lane squares.
   always_comb begin
      dsum = '0;
      for (int j = 0; j < MaxDims; j++) dsum = dsum + DistW'(sq[j]);
   end

   // The output register drops its beat when taken and loads a new one when free.
   always_comb begin
      rv_in = rv_ff && rsp_stall;
      if ((state_ff == S_MERGE || state_ff == S_OUT) && out_free) rv_in = 1'b1;
   end

   logic [ErrW:0] err_sum;
   assign err_sum = {1'b0, err_ff} + (ErrW+1)'(bestd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ncl_ff <= 4'd1;
         ndim_ff <= 3'd1;
         rv_ff <= 1'b0;
         err_ff <= '0;
         for (int k = 0; k < MaxClusters; k++) begin
            cnt_ff[k] <= '0;
            for (int j = 0; j < MaxDims; j++) begin
               cent_ff[k][j] <= '0;
               sum_ff[k][j] <= '0;
            end
         end
      end else begin
         rv_ff <= rv_in;
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == REG_DIMS) ndim_ff <= csr_pwdata[2:0];
            else ncl_ff <= csr_pwdata[3:0];
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pt_ff[0] <= req_data.coord0;
                  pt_ff[1] <= req_data.coord1;
                  pt_ff[2] <= req_data.coord2;
                  pt_ff[3] <= req_data.coord3;
                  k_ff <= '0;
                  dv_ff <= 1'b0;
                  dc_ff <= '0;
                  case (op_type'(req_data.operation))
                     OP_LOAD: begin
                        cent_ff[req_data.cluster_select][0] <= req_data.coord0;
                        cent_ff[req_data.cluster_select][1] <= req_data.coord1;
                        cent_ff[req_data.cluster_select][2] <= req_data.coord2;
                        cent_ff[req_data.cluster_select][3] <= req_data.coord3;
                     end
                     OP_ASSIGN: state_ff <= S_DIST;
                     OP_UPDATE: state_ff <= S_DIV;
                     default: ;
                  endcase
               end
            end
            S_DIST: begin
               // Lanes register the squares of cluster k_ff; compare the previous.
               dv_ff <= (k_ff < (ClW+1)'(nk));
               kd_ff <= k_ff;
               if (dv_ff && (kd_ff == 0 || dsum < bestd_ff)) begin
                  best_ff <= kd_ff[ClW-1:0];
                  bestd_ff <= dsum;
               end
               if (k_ff < (ClW+1)'(nk)) k_ff <= k_ff + 1'b1;
               else if (!dv_ff) state_ff <= S_ADD;
            end
            S_ADD: begin
               k_ff <= (ClW+1)'(best_ff);
               if (cnt_ff[best_ff] < CntW'(MaxPoints)) begin
                  cnt_ff[best_ff] <= cnt_ff[best_ff] + 1'b1;
                  for (int j = 0; j < MaxDims; j++)
                     if (3'(j) < nd)
                        sum_ff[best_ff][j] <= sum_ff[best_ff][j] + SumW'(pt_ff[j]);
                  err_ff <= err_sum[ErrW] ? '1 : err_sum[ErrW-1:0];
               end
               state_ff <= S_MERGE;
            end
            S_MERGE: begin
               if (out_free) begin
                  rsp_ff.cluster <= best_ff;
                  rsp_ff.sq_distance <= bestd_ff;
                  rsp_ff.cent0 <= cent_ff[best_ff][0];
                  rsp_ff.cent1 <= (nd > 1) ? cent_ff[best_ff][1] : '0;
                  rsp_ff.cent2 <= (nd > 2) ? cent_ff[best_ff][2] : '0;
                  rsp_ff.cent3 <= (nd > 3) ? cent_ff[best_ff][3] : '0;
                  rsp_ff.point_count <= cnt_ff[best_ff];
                  rsp_ff.empty_cluster <= 1'b0;
                  rsp_ff.total_error <= err_ff;
                  rsp_ff.last <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               if (dc_ff == DivCycW'(SumW)) state_ff <= S_EMIT;
               else dc_ff <= dc_ff + 1'b1;
            end
            S_EMIT: begin
               if (cnt_ff[k_ff[ClW-1:0]] != 0)
                  for (int j = 0; j < MaxDims; j++)
                     if (3'(j) < nd) cent_ff[k_ff[ClW-1:0]][j] <= quo[j];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_ff.cluster <= k_ff[ClW-1:0];
                  rsp_ff.sq_distance <= '0;
                  rsp_ff.cent0 <= cent_ff[k_ff[ClW-1:0]][0];
                  rsp_ff.cent1 <= (nd > 1) ? cent_ff[k_ff[ClW-1:0]][1] : '0;
                  rsp_ff.cent2 <= (nd > 2) ? cent_ff[k_ff[ClW-1:0]][2] : '0;
                  rsp_ff.cent3 <= (nd > 3) ? cent_ff[k_ff[ClW-1:0]][3] : '0;
                  rsp_ff.point_count <= cnt_ff[k_ff[ClW-1:0]];
                  rsp_ff.empty_cluster <= (cnt_ff[k_ff[ClW-1:0]] == 0);
                  rsp_ff.total_error <= err_ff;
                  rsp_ff.last <= (k_ff + 1'b1 == (ClW+1)'(nk));
                  dc_ff <= '0;
                  if (k_ff + 1'b1 == (ClW+1)'(nk)) begin
                     state_ff <= S_IDLE;
                     err_ff <= '0;
                     for (int k = 0; k < MaxClusters; k++) begin
                        cnt_ff[k] <= '0;
                        for (int j = 0; j < MaxDims; j++) sum_ff[k][j] <= '0;
                     end
                  end else begin
                     k_ff <= k_ff + 1'b1;
                     state_ff <= S_DIV;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !accept) else $error("item accepted while busy");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rsp_ff))) else $error("result lost");
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> ((ClW+1)'(best_ff) < (ClW+1)'(nk)))
      else $error("best cluster out of range");
`endif
endmodule
`default_nettype wire
